// ===== rtl/nmos_6502_alu_decimal_defines.svh =====
// Assertion macros used by the RTL.
`ifndef NMOS_6502_ALU_DECIMAL_DEFINES_SVH
`define NMOS_6502_ALU_DECIMAL_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define NMOS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nmos alu assertion failed");
// Checked on every clock edge, reset included.
`define NMOS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("nmos alu assertion failed");
`else
`define NMOS_ASSERT(label, clk, rst, prop)
`define NMOS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/nmos_alu_pkg.sv =====
`default_nettype none

package nmos_alu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    OP_ADC = 5'd0,
    OP_SBC = 5'd1,
    OP_CMP = 5'd2,
    OP_AND = 5'd3,
    OP_ORA = 5'd4,
    OP_EOR = 5'd5,
    OP_BIT = 5'd6,
    OP_ASL = 5'd7,
    OP_LSR = 5'd8,
    OP_ROL = 5'd9,
    OP_ROR = 5'd10,
    OP_INC = 5'd11,
    OP_DEC = 5'd12,
    OP_SLO = 5'd13,
    OP_RLA = 5'd14,
    OP_SRE = 5'd15,
    OP_RRA = 5'd16,
    OP_DCP = 5'd17,
    OP_ISC = 5'd18
  } op_t;

  // Status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Decimal correction constants
  localparam logic [3:0] BCD_DIGIT_ADJ = 4'h6;
  localparam logic [4:0] BCD_DIGIT_MAX = 5'h0A;
  localparam logic [8:0] BCD_HIGH_MAX  = 9'h0A0;
  localparam logic [7:0] BCD_HIGH_ADJ  = 8'h60;

  typedef struct packed {
    logic [4:0] req_type;
    logic [7:0] reg_in;
    logic [7:0] operand_in;
    logic [7:0] status_in;
  } req_t;

  typedef struct packed {
    logic [7:0] reg_out;
    logic [7:0] mem_out;
    logic [7:0] status_out;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/nmos_alu_core.sv =====
`default_nettype none

// Byte-wide ALU datapath, purely combinational.
module nmos_alu_core (
  input  nmos_alu_pkg::req_t req,
  output nmos_alu_pkg::rsp_t rsp
);

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] flags;
  } alu_res_t;

  // Z and N from a result byte
  function automatic logic [7:0] put_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[nmos_alu_pkg::FLAG_Z] = (v == 8'h00);
    q[nmos_alu_pkg::FLAG_N] = v[7];
    return q;
  endfunction

  // Compare: C is r >= m, Z/N from r - m
  function automatic logic [7:0] do_cmp(input logic [7:0] p, input logic [7:0] r,
                                        input logic [7:0] m);
    logic [7:0] q;
    q = put_zn(p, r - m);
    q[nmos_alu_pkg::FLAG_C] = (r >= m);
    return q;
  endfunction

  // Add with carry, binary or NMOS decimal
  function automatic alu_res_t do_adc(input logic [7:0] p, input logic [7:0] a,
                                      input logic [7:0] m);
    alu_res_t   res;
    logic [8:0] sum;
    logic [4:0] lo;
    logic [8:0] s;
    logic [9:0] s_adj;
    sum = {1'b0, a} + {1'b0, m} + {8'd0, p[nmos_alu_pkg::FLAG_C]};
    res.flags = p;
    if (p[nmos_alu_pkg::FLAG_D]) begin
      lo = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, p[nmos_alu_pkg::FLAG_C]};
      if (lo >= nmos_alu_pkg::BCD_DIGIT_MAX) begin
        lo = {1'b1, lo[3:0] + nmos_alu_pkg::BCD_DIGIT_ADJ};
      end
      s = {1'b0, a[7:4], 4'd0} + {1'b0, m[7:4], 4'd0} + {4'd0, lo};
      res.flags[nmos_alu_pkg::FLAG_N] = s[7];
      res.flags[nmos_alu_pkg::FLAG_V] = (a[7] ^ s[7]) & ~(a[7] ^ m[7]);
      s_adj = {1'b0, s};
      if (s >= nmos_alu_pkg::BCD_HIGH_MAX) begin
        s_adj = {1'b0, s} + {2'd0, nmos_alu_pkg::BCD_HIGH_ADJ};
      end
      res.flags[nmos_alu_pkg::FLAG_C] = (s_adj[9:8] != 2'd0);
      res.flags[nmos_alu_pkg::FLAG_Z] = (sum[7:0] == 8'h00);
      res.val = s_adj[7:0];
    end else begin
      res.val = sum[7:0];
      res.flags = put_zn(p, sum[7:0]);
      res.flags[nmos_alu_pkg::FLAG_C] = sum[8];
      res.flags[nmos_alu_pkg::FLAG_V] = (a[7] ^ sum[7]) & (m[7] ^ sum[7]);
    end
    return res;
  endfunction

  // Subtract with borrow; flags always from the binary difference
  function automatic alu_res_t do_sbc(input logic [7:0] p, input logic [7:0] a,
                                      input logic [7:0] m);
    alu_res_t   res;
    logic       borrow;
    logic [8:0] diff;
    logic [5:0] lo;
    logic [3:0] lo_fix;
    logic [9:0] d;
    borrow = ~p[nmos_alu_pkg::FLAG_C];
    diff = {1'b0, a} - {1'b0, m} - {8'd0, borrow};
    res.flags = put_zn(p, diff[7:0]);
    res.flags[nmos_alu_pkg::FLAG_C] = ~diff[8];
    res.flags[nmos_alu_pkg::FLAG_V] = (a[7] ^ m[7]) & (a[7] ^ diff[7]);
    res.val = diff[7:0];
    if (p[nmos_alu_pkg::FLAG_D]) begin
      lo = {2'd0, a[3:0]} - {2'd0, m[3:0]} - {5'd0, borrow};
      // low digit borrowed: correct it and keep it negative
      if (lo[5]) begin
        lo_fix = lo[3:0] - nmos_alu_pkg::BCD_DIGIT_ADJ;
        lo = {2'b11, lo_fix};
      end
      d = {2'd0, a[7:4], 4'd0} - {2'd0, m[7:4], 4'd0} + {{4{lo[5]}}, lo};
      res.val = d[9] ? (d[7:0] - nmos_alu_pkg::BCD_HIGH_ADJ) : d[7:0];
    end
    return res;
  endfunction

  logic [7:0] a;
  logic [7:0] m;
  logic [7:0] p;
  logic       cin;
  logic [7:0] m_asl;
  logic [7:0] m_lsr;
  logic [7:0] m_rol;
  logic [7:0] m_ror;
  logic [7:0] m_inc;
  logic [7:0] m_dec;
  logic [7:0] p_shl;
  logic [7:0] p_shr;
  alu_res_t   adc_res;
  alu_res_t   sbc_res;
  logic [7:0] adc_m;
  logic [7:0] sbc_m;
  logic [7:0] adc_p;
  logic [7:0] logic_val;

  assign a   = req.reg_in;
  assign m   = req.operand_in;
  assign p   = req.status_in;
  assign cin = p[nmos_alu_pkg::FLAG_C];

  // Shifted and stepped operand variants
  assign m_asl = {m[6:0], 1'b0};
  assign m_rol = {m[6:0], cin};
  assign m_lsr = {1'b0, m[7:1]};
  assign m_ror = {cin, m[7:1]};
  assign m_inc = m + 8'd1;
  assign m_dec = m - 8'd1;

  // Carry out of left and right shifts
  always_comb begin
    p_shl = p;
    p_shl[nmos_alu_pkg::FLAG_C] = m[7];
    p_shr = p;
    p_shr[nmos_alu_pkg::FLAG_C] = m[0];
  end

  // One adder and one subtractor, shared by the combined operations
  always_comb begin
    adc_m = m;
    adc_p = p;
    if (req.req_type == nmos_alu_pkg::OP_RRA) begin
      adc_m = m_ror;
      adc_p = p_shr;
    end
    sbc_m = (req.req_type == nmos_alu_pkg::OP_ISC) ? m_inc : m;
  end

  assign adc_res = do_adc(adc_p, a, adc_m);
  assign sbc_res = do_sbc(p, a, sbc_m);

  // Result select
  always_comb begin
    rsp.reg_out    = a;
    rsp.mem_out    = m;
    rsp.status_out = p;
    logic_val      = a;
    case (nmos_alu_pkg::op_t'(req.req_type))
      nmos_alu_pkg::OP_ADC: begin
        rsp.reg_out    = adc_res.val;
        rsp.status_out = adc_res.flags;
      end
      nmos_alu_pkg::OP_SBC: begin
        rsp.reg_out    = sbc_res.val;
        rsp.status_out = sbc_res.flags;
      end
      nmos_alu_pkg::OP_CMP: rsp.status_out = do_cmp(p, a, m);
      nmos_alu_pkg::OP_AND: begin
        logic_val      = a & m;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p, logic_val);
      end
      nmos_alu_pkg::OP_ORA: begin
        logic_val      = a | m;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p, logic_val);
      end
      nmos_alu_pkg::OP_EOR: begin
        logic_val      = a ^ m;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p, logic_val);
      end
      nmos_alu_pkg::OP_BIT: begin
        rsp.status_out[nmos_alu_pkg::FLAG_Z] = ((a & m) == 8'h00);
        rsp.status_out[nmos_alu_pkg::FLAG_N] = m[7];
        rsp.status_out[nmos_alu_pkg::FLAG_V] = m[6];
      end
      nmos_alu_pkg::OP_ASL: begin
        rsp.mem_out    = m_asl;
        rsp.status_out = put_zn(p_shl, m_asl);
      end
      nmos_alu_pkg::OP_LSR: begin
        rsp.mem_out    = m_lsr;
        rsp.status_out = put_zn(p_shr, m_lsr);
      end
      nmos_alu_pkg::OP_ROL: begin
        rsp.mem_out    = m_rol;
        rsp.status_out = put_zn(p_shl, m_rol);
      end
      nmos_alu_pkg::OP_ROR: begin
        rsp.mem_out    = m_ror;
        rsp.status_out = put_zn(p_shr, m_ror);
      end
      nmos_alu_pkg::OP_INC: begin
        rsp.mem_out    = m_inc;
        rsp.status_out = put_zn(p, m_inc);
      end
      nmos_alu_pkg::OP_DEC: begin
        rsp.mem_out    = m_dec;
        rsp.status_out = put_zn(p, m_dec);
      end
      nmos_alu_pkg::OP_SLO: begin
        logic_val      = a | m_asl;
        rsp.mem_out    = m_asl;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p_shl, logic_val);
      end
      nmos_alu_pkg::OP_RLA: begin
        logic_val      = a & m_rol;
        rsp.mem_out    = m_rol;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p_shl, logic_val);
      end
      nmos_alu_pkg::OP_SRE: begin
        logic_val      = a ^ m_lsr;
        rsp.mem_out    = m_lsr;
        rsp.reg_out    = logic_val;
        rsp.status_out = put_zn(p_shr, logic_val);
      end
      nmos_alu_pkg::OP_RRA: begin
        rsp.mem_out    = m_ror;
        rsp.reg_out    = adc_res.val;
        rsp.status_out = adc_res.flags;
      end
      nmos_alu_pkg::OP_DCP: begin
        rsp.mem_out    = m_dec;
        rsp.status_out = do_cmp(p, a, m_dec);
      end
      nmos_alu_pkg::OP_ISC: begin
        rsp.mem_out    = m_inc;
        rsp.reg_out    = sbc_res.val;
        rsp.status_out = sbc_res.flags;
      end
      default: begin
        // unknown code: transaction passes through unchanged
        rsp.reg_out    = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/nmos_6502_alu_decimal.sv =====
// NMOS 6502 ALU with decimal mode.
// Request channel: req_valid / req_stall carry req_data (operation code,
// register operand, memory operand, status byte). Response channel:
// rsp_valid / rsp_stall carry rsp_data (new register, modified memory
// operand, new status byte). A transaction moves on an edge with valid high
// and stall low.
// A request passes through the input register, then the ALU logic, then
// the result register. Throughput is one transaction per cycle unless the
// response stalls; the single ALU pass between the two registers sets it.
// A stalled response holds rsp_data steady. While the response waits, one
// more request is still taken into the input register; req_stall rises
// only when both registers are full and the response is stalled.
// Reset (rst, synchronous) empties both registers; no response is pending
// afterward and the block takes a request in the next cycle.
`default_nettype none
`include "nmos_6502_alu_decimal_defines.svh"

module nmos_6502_alu_decimal (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  nmos_alu_pkg::req_t req_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output nmos_alu_pkg::rsp_t rsp_data
);

  logic               s1_valid;
  nmos_alu_pkg::req_t s1_q;
  nmos_alu_pkg::rsp_t core_rsp;
  logic               rsp_ready;
  logic               s1_adv;

  // Stage handshake
  assign rsp_ready = ~rsp_valid | ~rsp_stall;
  assign s1_adv    = s1_valid & rsp_ready;
  assign req_stall = s1_valid & ~rsp_ready;

  nmos_alu_core u_core (
    .req (s1_q),
    .rsp (core_rsp)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (!req_stall) s1_valid <= req_valid;
      if (rsp_ready) rsp_valid <= s1_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) s1_q <= req_data;
    if (s1_adv) rsp_data <= core_rsp;
  end

  // Checks
  `NMOS_ASSERT(a_req_lands, clk, rst, req_valid && !req_stall |=> s1_valid)
  `NMOS_ASSERT(a_s1_kept, clk, rst, s1_valid && !s1_adv |=> s1_valid && $stable(s1_q))
  `NMOS_ASSERT(a_unknown_pass, clk, rst,
    s1_adv && s1_q.req_type > nmos_alu_pkg::OP_ISC |=>
    rsp_data.status_out == $past(s1_q.status_in) &&
    rsp_data.mem_out == $past(s1_q.operand_in))
  `NMOS_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid && !s1_valid)

endmodule

`default_nettype wire
